// ----- rtl/core/mhsd_pkg.sv -----
// Package for the magic header stream deframer: field widths, constants, FSM codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mhsd_pkg;
  localparam int OFFSET_BITS = 48;
  localparam logic [7:0] MAGIC_FIRST = 8'h33;
  localparam logic [7:0] MAGIC_SECOND = 8'h66;
  localparam logic [4:0] BASE_LEN = 5'd21;
  localparam logic [22:0] LIMIT_CAP = 23'd4194304;
  localparam logic [1:0] CFG_TAG = 2'd0;
  localparam logic [1:0] CFG_DIR = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_EXT = 2'd1;
  localparam logic [1:0] KIND_BODY = 2'd2;

  typedef enum logic [6:0] {
    ST_HUNT    = 7'b0000001,
    ST_HEADER  = 7'b0000010,
    ST_CHECK   = 7'b0000100,
    ST_DECIDE  = 7'b0001000,
    ST_PAYLOAD = 7'b0010000,
    ST_REPLAY  = 7'b0100000,
    ST_RECAP   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       take;       // input transfer this cycle
    logic       capture;    // store byte in header
    logic       hunt;       // run the hunter on the current byte
    logic       check;      // evaluate header
    logic       emit_hdr;   // load output with header result
    logic       emit_pay;   // load output with payload byte
    logic       replay_init;
    logic       replay_step;
  } cmd_t;

  typedef struct packed {
    logic       magic_hit;  // current hunt byte completes magic
    logic       hdr_full;   // 21st byte arrives
    logic       hdr_ok;
    logic       none_left;  // header leaves no payload bytes
    logic       pay_last;
    logic       replay_done;
    logic       replay_hit;
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] versions;
    logic [15:0] command_code;
    logic        encrypted;
    logic [31:0] sequence_res;
    logic [22:0] head_length;
    logic [21:0] body_length;
    logic [47:0] stream_offset;
    logic        last;
    logic [15:0] tag_out;
    logic        direction_out;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/core/mhsd_if.sv -----
// Valid/ready channel interfaces for byte input and result output.
// Depends on mhsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mhsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface mhsd_result_if;
  logic                valid;
  logic                ready;
  mhsd_pkg::result_t   res;
  modport source(output valid, output res, input ready);
  modport sink(input valid, input res, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mhsd_datapath.sv -----
// Datapath: header store, length check, counters, replay pointer, output register.
// Depends on mhsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mhsd_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mhsd_pkg::cmd_t       cmd,
  output mhsd_pkg::status_t         status,
  input  wire logic                 hunt_mode,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [22:0]          cfg_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output mhsd_pkg::result_t         out_res
);
  logic [15:0] flow_tag;
  logic        flow_dir;
  logic [22:0] max_len;
  logic [7:0]  hstore [21];
  logic [4:0]  hcount;
  logic [4:0]  rindex;
  logic        half;
  logic [47:0] pos;
  logic [47:0] fstart;
  logic [22:0] remaining;
  logic [31:0] lv_vers;
  logic [15:0] lv_cmd;
  logic        lv_enc;
  logic [31:0] lv_seq;
  logic [22:0] lv_hl;
  logic [21:0] lv_bl;
  logic        ok_reg;
  logic [22:0] rem_reg;

  logic [7:0]  hb;
  logic [15:0] c16;
  logic [31:0] hl32, bl32;
  logic [32:0] sum;
  logic [22:0] lim;
  logic        ok;
  logic        hit;

  // hunt byte: replayed store byte or live input
  always_comb begin
    hb = hunt_mode ? in_byte : hstore[rindex];
    hit = half && (hb == mhsd_pkg::MAGIC_SECOND);
    c16 = {hstore[6], hstore[7]};
    hl32 = {hstore[13], hstore[14], hstore[15], hstore[16]};
    bl32 = {hstore[17], hstore[18], hstore[19], hstore[20]};
    sum = {1'b0, hl32} + {1'b0, bl32};
    lim = (max_len > mhsd_pkg::LIMIT_CAP) ? mhsd_pkg::LIMIT_CAP : max_len;
    ok = (c16 != 16'd0) && (hl32 >= 32'(mhsd_pkg::BASE_LEN)) && (sum <= 33'(lim));
  end

  assign status.magic_hit   = hit;
  assign status.hdr_full    = (hcount == mhsd_pkg::BASE_LEN - 5'd1);
  assign status.hdr_ok      = ok_reg;
  assign status.none_left   = (rem_reg == 23'd0);
  assign status.pay_last    = (remaining <= 23'd1);
  assign status.replay_done = (rindex == mhsd_pkg::BASE_LEN - 5'd1);
  assign status.replay_hit  = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_tag <= '0;
      flow_dir <= 1'b0;
      max_len <= mhsd_pkg::LIMIT_CAP;
      half <= 1'b0;
      pos <= '0;
      hcount <= '0;
      rindex <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
      lv_vers <= '0; lv_cmd <= '0; lv_enc <= 1'b0;
      lv_seq <= '0; lv_hl <= '0; lv_bl <= '0;
      fstart <= '0;
      ok_reg <= 1'b0;
      rem_reg <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mhsd_pkg::CFG_TAG:   flow_tag <= cfg_data[15:0];
          mhsd_pkg::CFG_DIR:   flow_dir <= cfg_data[0];
          mhsd_pkg::CFG_LIMIT: max_len <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit_hdr || cmd.emit_pay) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.take) pos <= pos + 48'd1;
      // hunter, live or replayed
      if (cmd.hunt) begin
        if (hit) begin
          half <= 1'b0;
          hstore[0] <= mhsd_pkg::MAGIC_FIRST;
          hstore[1] <= mhsd_pkg::MAGIC_SECOND;
          hcount <= 5'd2;
          fstart <= hunt_mode ? pos - 48'd1
                              : fstart + 48'(rindex) - 48'd1;
        end else begin
          half <= (hb == mhsd_pkg::MAGIC_FIRST);
        end
      end
      if (cmd.capture) begin
        hstore[hcount] <= hb;
        hcount <= hcount + 5'd1;
      end
      if (cmd.check) begin
        ok_reg <= ok;
        rem_reg <= hl32[22:0] - 23'(mhsd_pkg::BASE_LEN) + bl32[22:0];
        hcount <= '0;
        if (ok) begin
          lv_vers <= {hstore[2], hstore[3], hstore[4], hstore[5]};
          lv_cmd <= c16;
          lv_enc <= (hstore[8] != 8'd0);
          lv_seq <= {hstore[9], hstore[10], hstore[11], hstore[12]};
          lv_hl <= hl32[22:0];
          lv_bl <= bl32[21:0];
        end
      end
      if (cmd.replay_init) begin
        half <= 1'b0;
        rindex <= 5'd2;
      end else if (cmd.replay_step) begin
        rindex <= rindex + 5'd1;
      end
      if (cmd.emit_hdr) begin
        remaining <= rem_reg;
        out_res.kind <= mhsd_pkg::KIND_HEADER;
        out_res.payload_byte <= 8'd0;
        out_res.last <= (rem_reg == 23'd0);
      end
      if (cmd.emit_pay) begin
        remaining <= (remaining != 23'd0) ? remaining - 23'd1 : remaining;
        out_res.kind <= (remaining > {1'b0, lv_bl}) ? mhsd_pkg::KIND_EXT
                                                    : mhsd_pkg::KIND_BODY;
        out_res.payload_byte <= in_byte;
        out_res.last <= (remaining <= 23'd1);
      end
      if (cmd.emit_hdr || cmd.emit_pay) begin
        out_res.versions <= cmd.emit_hdr ? {hstore[2], hstore[3], hstore[4], hstore[5]}
                                         : lv_vers;
        out_res.command_code <= lv_cmd;
        out_res.encrypted <= lv_enc;
        out_res.sequence_res <= lv_seq;
        out_res.head_length <= lv_hl;
        out_res.body_length <= lv_bl;
        out_res.stream_offset <= fstart;
        out_res.tag_out <= flow_tag;
        out_res.direction_out <= flow_dir;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/mhsd_ctrl.sv -----
// Controller FSM: hunt, capture, check, cut-through payload, replay.
// Depends on mhsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mhsd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire mhsd_pkg::status_t  status,
  output mhsd_pkg::cmd_t          cmd,
  output logic                    hunt_mode
);
  mhsd_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    hunt_mode = 1'b1;
    case (state)
      mhsd_pkg::ST_HUNT: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        cmd.hunt = in_valid;
        if (in_valid && status.magic_hit) state_next = mhsd_pkg::ST_HEADER;
      end
      mhsd_pkg::ST_HEADER: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        cmd.capture = in_valid;
        if (in_valid && status.hdr_full) state_next = mhsd_pkg::ST_CHECK;
      end
      mhsd_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_next = mhsd_pkg::ST_DECIDE;
      end
      mhsd_pkg::ST_DECIDE: begin
        // after check, decides emit (once the output is free) or replay
        if (status.hdr_ok) begin
          if (out_free) begin
            cmd.emit_hdr = 1'b1;
            state_next = status.none_left ? mhsd_pkg::ST_HUNT : mhsd_pkg::ST_PAYLOAD;
          end
        end else begin
          cmd.replay_init = 1'b1;
          state_next = mhsd_pkg::ST_REPLAY;
        end
      end
      mhsd_pkg::ST_PAYLOAD: begin
        in_ready = out_free;
        cmd.take = in_valid && out_free;
        cmd.emit_pay = in_valid && out_free;
        if (in_valid && out_free && status.pay_last) state_next = mhsd_pkg::ST_HUNT;
      end
      mhsd_pkg::ST_REPLAY: begin
        hunt_mode = 1'b0;
        cmd.hunt = 1'b1;
        cmd.replay_step = 1'b1;
        if (status.replay_hit) begin
          state_next = status.replay_done ? mhsd_pkg::ST_HEADER : mhsd_pkg::ST_RECAP;
        end else if (status.replay_done) begin
          state_next = mhsd_pkg::ST_HUNT;
        end
      end
      mhsd_pkg::ST_RECAP: begin
        // rest of the replayed bytes become header bytes
        hunt_mode = 1'b0;
        cmd.capture = 1'b1;
        cmd.replay_step = 1'b1;
        if (status.replay_done) state_next = mhsd_pkg::ST_HEADER;
      end
      default: state_next = mhsd_pkg::ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mhsd_pkg::ST_HUNT;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ----- rtl/core/magic_header_stream_deframer_unit.sv -----
// Top level of the magic header stream deframer: controller plus datapath.
// Depends on mhsd_pkg, mhsd_if, mhsd_ctrl, mhsd_datapath.
//
// Byte input on in_ch (valid/ready); at most one result per transfer on out_ch.
// Hunts 0x33 0x66, captures the 21-byte header, checks it, then passes the
// extension and body bytes through with the header fields attached.
// Hunting and header bytes are taken whenever input is valid. After the 21st
// header byte no input is taken in the check and decide states (header result
// or start of resync); the header result is held in the output register.
// A payload byte gives its result in the cycle after its transfer; a payload
// byte is taken whenever the output register is empty or being drained.
// An invalid header is replayed from byte 2 through byte 20, one byte a cycle,
// during which no input is taken; a magic found during replay turns
// the rest of the replayed bytes into header bytes, and capture then
// continues from the live stream.
// Receiver stall holds the output register and back-pressures payload input.
// rst (synchronous) clears state, positions and registers except the header
// store and output fields; the limit resets to 4194304.
`timescale 1ns / 1ps
`default_nettype none
module magic_header_stream_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  mhsd_byte_if.sink        in_ch,
  mhsd_result_if.source    out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [22:0] cfg_data
);
  mhsd_pkg::cmd_t    cmd;
  mhsd_pkg::status_t status;
  logic              hunt_mode;

  mhsd_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status, .cmd, .hunt_mode
  );

  mhsd_datapath u_dp (
    .clk, .rst, .cmd, .status, .hunt_mode,
    .in_byte(in_ch.data_byte),
    .cfg_we, .cfg_index, .cfg_data,
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_res(out_ch.res)
  );
endmodule
`default_nettype wire

// ----- rtl/core/mhsd_checker.sv -----
// Port-level checker for the deframer, bound to the top level.
// Depends on mhsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mhsd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire mhsd_pkg::result_t out_res
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed under stall");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.kind != 2'd3)
    else $error("bad kind");
  a_hdr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == mhsd_pkg::KIND_HEADER |-> out_res.payload_byte == 8'd0)
    else $error("header result with payload");
  a_hl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.head_length >= 23'd21)
    else $error("short head length");
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready}))
    else $error("unknown input handshake");
endmodule

bind magic_header_stream_deframer_unit mhsd_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(out_ch.res)
);
`default_nettype wire
